// ===== hdl/dflt_pkg.sv =====
package dflt_pkg;

  localparam int FRAC_BITS  = 20;
  localparam int MAX_POINTS = 4096;
  localparam int UNIT_BITS  = 26;
  localparam int PNUM_W     = $clog2(MAX_POINTS);
  localparam int LIMIT_W    = PNUM_W + 1;

  // positions at or below this magnitude do not move
  localparam int ZERO_LSB = (1 << FRAC_BITS) / 100000;

  // iteration counts of the shared divide / root unit
  localparam int DIV_STEPS  = 27;
  localparam int SQRT_STEPS = 32;

  localparam int CFG_W = 31;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_AXIS_X       = 3'd0;
  localparam logic [IDX_W-1:0] REG_AXIS_Y       = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 3'd3;
  localparam logic [IDX_W-1:0] REG_POINT_LIMIT  = 3'd4;

  typedef struct packed {
    logic go;
    logic op_sqrt;
  } dflt_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] res;
  } dflt_resp_t;

endpackage

// ===== hdl/dflt_if.sv =====
interface dflt_seed_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] seed_x;
  logic signed [31:0] seed_y;
  logic signed [31:0] seed_z;

  modport source (output valid, action, seed_x, seed_y, seed_z, input ready);
  modport sink (input valid, action, seed_x, seed_y, seed_z, output ready);
endinterface

interface dflt_point_if import dflt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [PNUM_W-1:0]  point_number;
  logic               last;

  modport source (output valid, point_x, point_y, point_z, point_number, last,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_number, last,
                output ready);
endinterface

// ===== hdl/dipole_field_line_tracer.sv =====
// channel  dir  word                                 handshake
// seed     in   action, seed_x, seed_y, seed_z       valid / ready
// point    out  point_x/y/z, point_number, last      valid / ready
// wr_*     in   wr_index, wr_data                    wr_en, no wait
//
// an advance runs on the shared divide / root unit: two 32-step roots and
// six 27-step divides
// a held position skips to the escape test, near zero or with no field
// seed.ready is high only while the sequencer is idle
// the point register holds one word; the next word is accepted while it waits
// synchronous reset clears the line, the registers take their default values
module dipole_field_line_tracer import dflt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dflt_seed_if.sink         seed,
  dflt_point_if.source      point,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [CFG_W-1:0]  wr_data
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_SQ         = 5'd1;
  localparam logic [4:0] S_SQ_ACC     = 5'd2;
  localparam logic [4:0] S_MSQRT_GO   = 5'd3;
  localparam logic [4:0] S_MSQRT_WAIT = 5'd4;
  localparam logic [4:0] S_UDIV_GO    = 5'd5;
  localparam logic [4:0] S_UDIV_WAIT  = 5'd6;
  localparam logic [4:0] S_C_MUL      = 5'd7;
  localparam logic [4:0] S_C_ACC      = 5'd8;
  localparam logic [4:0] S_V_MUL      = 5'd9;
  localparam logic [4:0] S_V_SET      = 5'd10;
  localparam logic [4:0] S_VSQ        = 5'd11;
  localparam logic [4:0] S_VSQ_ACC    = 5'd12;
  localparam logic [4:0] S_VSQRT_GO   = 5'd13;
  localparam logic [4:0] S_VSQRT_WAIT = 5'd14;
  localparam logic [4:0] S_DMUL       = 5'd15;
  localparam logic [4:0] S_DDIV_GO    = 5'd16;
  localparam logic [4:0] S_DDIV_WAIT  = 5'd17;
  localparam logic [4:0] S_ESQ        = 5'd18;
  localparam logic [4:0] S_ESQ_ACC    = 5'd19;
  localparam logic [4:0] S_EMD        = 5'd20;
  localparam logic [4:0] S_ECMP       = 5'd21;
  localparam logic [4:0] S_FIN        = 5'd22;

  // configuration
  logic [17:0] axis_x;
  logic [17:0] axis_y;
  logic [24:0] step_size;
  logic [30:0] max_distance;
  logic [12:0] point_limit;

  // control
  logic [4:0]        state;
  logic [1:0]        idx;
  logic              active;
  logic [PNUM_W-1:0] emitted;

  // datapath
  logic signed [31:0] px, py, pz;
  logic signed [31:0] ox, oy, oz;
  logic [63:0]        acc;
  logic [63:0]        acc_sum;
  logic [32:0]        root;
  logic signed [27:0] u0, u1, u2;
  logic signed [29:0] c;
  logic signed [31:0] v0, v1, v2;
  logic signed [65:0] prod;
  logic signed [65:0] prod_neg;
  logic signed [32:0] mul_a, mul_b;
  logic               dneg;
  logic               escaped;

  logic signed [31:0] cur_p;
  logic signed [27:0] cur_u;
  logic signed [31:0] cur_v;
  logic signed [32:0] cur_axis;
  logic signed [31:0] cur_a;
  logic [31:0]        abs_p;

  logic [DIV_STEPS-1:0] quo;
  logic signed [27:0]   u_new;
  logic signed [29:0]   fl;
  logic signed [31:0]   fl32;
  logic signed [31:0]   v_new;
  logic signed [32:0]   d33;
  logic signed [32:0]   psum;
  logic signed [31:0]   p_new;

  logic [LIMIT_W-1:0] limit;
  logic               last_now;
  logic               out_free;

  dflt_req_t  req;
  dflt_resp_t resp;
  logic [63:0] unit_num;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x       <= 18'd0;
      axis_y       <= 18'd65536;
      step_size    <= 25'd52429;
      max_distance <= 31'd419430400;
      point_limit  <= 13'd1061;
    end else if (wr_en) begin
      case (wr_index)
        REG_AXIS_X:       axis_x       <= wr_data[17:0];
        REG_AXIS_Y:       axis_y       <= wr_data[17:0];
        REG_STEP_SIZE:    step_size    <= wr_data[24:0];
        REG_MAX_DISTANCE: max_distance <= wr_data[30:0];
        REG_POINT_LIMIT:  point_limit  <= wr_data[12:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- selection
  always_comb begin
    case (idx)
      2'd0: begin
        cur_p    = px;
        cur_u    = u0;
        cur_v    = v0;
        cur_axis = {{15{axis_x[17]}}, axis_x};
        cur_a    = {{4{axis_x[17]}}, axis_x, 10'b0};
      end
      2'd1: begin
        cur_p    = py;
        cur_u    = u1;
        cur_v    = v1;
        cur_axis = {{15{axis_y[17]}}, axis_y};
        cur_a    = {{4{axis_y[17]}}, axis_y, 10'b0};
      end
      default: begin
        cur_p    = pz;
        cur_u    = u2;
        cur_v    = v2;
        cur_axis = '0;
        cur_a    = '0;
      end
    endcase
  end

  assign abs_p = cur_p[31] ? (32'd0 - cur_p) : cur_p;

  // shared multiplier, product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ, S_ESQ: begin
        mul_a = {cur_p[31], cur_p};
        mul_b = {cur_p[31], cur_p};
      end
      S_C_MUL: begin
        mul_a = {{5{cur_u[27]}}, cur_u};
        mul_b = cur_axis;
      end
      S_V_MUL: begin
        mul_a = {{3{c[29]}}, c};
        mul_b = {{5{cur_u[27]}}, cur_u};
      end
      S_VSQ: begin
        mul_a = {cur_v[31], cur_v};
        mul_b = {cur_v[31], cur_v};
      end
      S_DMUL: begin
        mul_a = {cur_v[31], cur_v};
        mul_b = {8'b0, step_size};
      end
      S_EMD: begin
        mul_a = {2'b0, max_distance};
        mul_b = {2'b0, max_distance};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign acc_sum  = acc + prod[63:0];
  assign prod_neg = -prod;

  // ------------------------------------------------------ divide / root unit
  assign req.go      = (state == S_MSQRT_GO) || (state == S_UDIV_GO) ||
                       (state == S_VSQRT_GO) || (state == S_DDIV_GO);
  assign req.op_sqrt = (state == S_MSQRT_GO) || (state == S_VSQRT_GO);

  always_comb begin
    case (state)
      S_UDIV_GO: unit_num = {6'b0, abs_p, {UNIT_BITS{1'b0}}};
      S_DDIV_GO: unit_num = prod[65] ? prod_neg[63:0] : prod[63:0];
      default:   unit_num = acc;
    endcase
  end

  dflt_divsqrt u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .num  (unit_num),
    .den  (root),
    .resp (resp)
  );

  assign quo   = resp.res[DIV_STEPS-1:0];
  assign u_new = cur_p[31] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign fl    = prod[UNIT_BITS+29:UNIT_BITS];
  assign fl32  = {{2{fl[29]}}, fl};
  assign v_new = (fl32 <<< 1) + fl32 - cur_a;

  assign d33   = dneg ? -$signed({{(33 - DIV_STEPS){1'b0}}, quo})
                      : $signed({{(33 - DIV_STEPS){1'b0}}, quo});
  assign psum  = {cur_p[31], cur_p} + d33;
  assign p_new = (psum[32] != psum[31]) ? (psum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                        : psum[31:0];

  // ------------------------------------------------------------ end of line
  always_comb begin
    if (point_limit == '0) begin
      limit = LIMIT_W'(1);
    end else if (int'(point_limit) > MAX_POINTS) begin
      limit = LIMIT_W'(MAX_POINTS);
    end else begin
      limit = LIMIT_W'(point_limit);
    end
  end

  assign last_now = escaped || (({1'b0, emitted} + 1'b1) >= limit);
  assign out_free = !point.valid || point.ready;

  assign seed.ready = (state == S_IDLE);

  // -------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      active      <= 1'b0;
      emitted     <= '0;
      point.valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        point.valid <= 1'b1;
      end else if (point.ready) begin
        point.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (seed.valid) begin
            if (!seed.action) begin
              active  <= 1'b1;
              emitted <= '0;
            end else if (active) begin
              state <= S_SQ;
            end
          end
        end
        S_SQ: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_MSQRT_GO;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ;
          end
        end
        S_MSQRT_GO: state <= S_MSQRT_WAIT;
        S_MSQRT_WAIT: begin
          if (resp.done) begin
            idx   <= '0;
            state <= (resp.res <= 33'(ZERO_LSB)) ? S_ESQ : S_UDIV_GO;
          end
        end
        S_UDIV_GO: state <= S_UDIV_WAIT;
        S_UDIV_WAIT: begin
          if (resp.done) begin
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= S_C_MUL;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_UDIV_GO;
            end
          end
        end
        S_C_MUL: state <= S_C_ACC;
        S_C_ACC: begin
          if (idx == 2'd1) begin
            idx   <= '0;
            state <= S_V_MUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_C_MUL;
          end
        end
        S_V_MUL: state <= S_V_SET;
        S_V_SET: begin
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_VSQ;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_V_MUL;
          end
        end
        S_VSQ: state <= S_VSQ_ACC;
        S_VSQ_ACC: begin
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_VSQRT_GO;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_VSQ;
          end
        end
        S_VSQRT_GO: state <= S_VSQRT_WAIT;
        S_VSQRT_WAIT: begin
          if (resp.done) begin
            idx   <= '0;
            state <= (resp.res == '0) ? S_ESQ : S_DMUL;
          end
        end
        S_DMUL:    state <= S_DDIV_GO;
        S_DDIV_GO: state <= S_DDIV_WAIT;
        S_DDIV_WAIT: begin
          if (resp.done) begin
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= S_ESQ;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DMUL;
            end
          end
        end
        S_ESQ: state <= S_ESQ_ACC;
        S_ESQ_ACC: begin
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_EMD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ESQ;
          end
        end
        S_EMD:  state <= S_ECMP;
        S_ECMP: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            emitted <= emitted + 1'b1;
            if (last_now) begin
              active <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (seed.valid) begin
          if (!seed.action) begin
            px <= seed.seed_x;
            py <= seed.seed_y;
            pz <= seed.seed_z;
          end else begin
            ox <= px;
            oy <= py;
            oz <= pz;
          end
        end
        acc <= '0;
      end
      S_SQ_ACC, S_VSQ_ACC, S_ESQ_ACC: acc <= acc_sum;
      S_C_ACC: begin
        acc <= acc_sum;
        // floor of the dot product, back to Q.26
        c   <= acc_sum[45:16];
      end
      S_MSQRT_WAIT, S_VSQRT_WAIT: begin
        acc <= '0;
        if (resp.done) begin
          root <= resp.res;
        end
      end
      S_UDIV_WAIT: begin
        if (resp.done) begin
          case (idx)
            2'd0:    u0 <= u_new;
            2'd1:    u1 <= u_new;
            default: u2 <= u_new;
          endcase
        end
      end
      S_V_SET: begin
        acc <= '0;
        case (idx)
          2'd0:    v0 <= v_new;
          2'd1:    v1 <= v_new;
          default: v2 <= v_new;
        endcase
      end
      S_DDIV_GO: dneg <= prod[65];
      S_DDIV_WAIT: begin
        acc <= '0;
        if (resp.done) begin
          case (idx)
            2'd0:    px <= p_new;
            2'd1:    py <= p_new;
            default: pz <= p_new;
          endcase
        end
      end
      S_ECMP: escaped <= acc > prod[63:0];
      S_FIN: begin
        if (out_free) begin
          point.point_x      <= ox;
          point.point_y      <= oy;
          point.point_z      <= oz;
          point.point_number <= emitted;
          point.last         <= last_now;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    resp.done |-> (state == S_MSQRT_WAIT || state == S_UDIV_WAIT ||
                   state == S_VSQRT_WAIT || state == S_DDIV_WAIT))
    else $error("unit finished outside a wait state");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (point.valid && state == S_IDLE))
    else $error("finished point not presented");

  a_line_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(active)) |-> (point.valid && point.last))
    else $error("line ended without a last point");

  a_unit_idle_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !req.go)
    else $error("unit started while idle");
`endif

endmodule

// ===== hdl/dflt_divsqrt.sv =====
module dflt_divsqrt import dflt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dflt_req_t   req,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output dflt_resp_t  resp
);

  localparam int CNT_W = $clog2(SQRT_STEPS);

  logic             busy;
  logic             done;
  logic             op_sqrt;
  logic [CNT_W-1:0] cnt;
  logic             last_step;

  // root: remainder and partial root
  logic [63:0] sq_x;
  logic [63:0] sq_r;
  logic [63:0] bit_b;
  logic [64:0] trial;
  logic        sq_take;

  // divide: partial remainder, dividend bits still to come, quotient
  logic [32:0]          rem;
  logic [DIV_STEPS-1:0] nsh;
  logic [DIV_STEPS-1:0] quo;
  logic [32:0]          den_q;
  logic [33:0]          dtrial;
  logic [33:0]          ddiff;
  logic                 d_take;

  assign bit_b   = 64'd1 << (6'(2 * SQRT_STEPS - 2) - {cnt, 1'b0});
  assign trial   = {1'b0, sq_r} + {1'b0, bit_b};
  assign sq_take = {1'b0, sq_x} >= trial;

  assign dtrial = {rem, nsh[DIV_STEPS-1]};
  assign ddiff  = dtrial - {1'b0, den_q};
  assign d_take = dtrial >= {1'b0, den_q};

  assign last_step = op_sqrt ? (cnt == CNT_W'(SQRT_STEPS - 1))
                             : (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.go && last_step;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      op_sqrt <= req.op_sqrt;
      sq_x    <= num;
      sq_r    <= '0;
      // quotient fits in DIV_STEPS bits, so the high part is already below den
      rem     <= num[DIV_STEPS+32:DIV_STEPS];
      nsh     <= num[DIV_STEPS-1:0];
      quo     <= '0;
      den_q   <= den;
    end else if (busy) begin
      if (op_sqrt) begin
        if (sq_take) begin
          sq_x <= sq_x - trial[63:0];
          sq_r <= (sq_r >> 1) + bit_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end else begin
        rem <= d_take ? ddiff[32:0] : dtrial[32:0];
        nsh <= nsh << 1;
        quo <= {quo[DIV_STEPS-2:0], d_take};
      end
    end
  end

  assign resp.done = done;
  assign resp.res  = op_sqrt ? sq_r[32:0] : {{(33 - DIV_STEPS){1'b0}}, quo};

endmodule
